/* hw/rtl/mil_pkg.sv */
package mil_pkg;

  localparam int DATA_W      = 32;
  localparam int MAX_N_DEF   = 8;
  localparam int FRAC_DEF    = 16;
  localparam int SIZE_W      = 4;
  localparam logic [SIZE_W-1:0] SIZE_RST = 4'd4;

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_E_PIV,
    ST_E_NUM,
    ST_E_DIV,
    ST_E_DWAIT,
    ST_E_KRD,
    ST_E_KMUL,
    ST_E_KWAIT,
    ST_F_RD,
    ST_F_MUL,
    ST_F_WAIT,
    ST_F_WR,
    ST_B_RD,
    ST_B_MUL,
    ST_B_WAIT,
    ST_B_RDZ,
    ST_B_DIV,
    ST_B_DWAIT,
    ST_O_RD,
    ST_O_LD,
    ST_O_WAIT
  } mil_state_e;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] prod;
  } mul_res_t;

  typedef struct packed {
    logic                     done;
    logic                     zero;
    logic signed [DATA_W-1:0] quot;
  } div_res_t;

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? WORD_MIN : WORD_MAX;
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? WORD_MIN : WORD_MAX;
    return s[DATA_W-1:0];
  endfunction

endpackage

/* hw/rtl/mil_mul.sv */
module mil_mul #(
  parameter int FRAC_BITS = mil_pkg::FRAC_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [mil_pkg::DATA_W-1:0]   a_i,
  input  logic signed [mil_pkg::DATA_W-1:0]   b_i,
  output mil_pkg::mul_res_t                   res_o
);
  import mil_pkg::*;

  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [2*DATA_W-1:0] shifted;
  logic signed [DATA_W-1:0]   res_q;
  logic                       v1_q, v2_q;

  // arithmetic shift floors toward minus infinity
  assign shifted = prod_q >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (shifted > 64'(WORD_MAX)) res_q <= WORD_MAX;
    else if (shifted < 64'(WORD_MIN)) res_q <= WORD_MIN;
    else res_q <= shifted[DATA_W-1:0];
  end

  assign res_o.done = v2_q;
  assign res_o.prod = res_q;

endmodule

/* hw/rtl/mil_div.sv */
module mil_div #(
  parameter int FRAC_BITS = mil_pkg::FRAC_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [mil_pkg::DATA_W-1:0]   a_i,
  input  logic signed [mil_pkg::DATA_W-1:0]   b_i,
  output mil_pkg::div_res_t                   res_o
);
  import mil_pkg::*;

  localparam int NW = DATA_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]     numq_q;
  logic [DATA_W-1:0] rem_q, den_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q, neg_q, zero_q;
  logic signed [DATA_W-1:0] quot_q;
  logic [DATA_W:0]   rem_sh;
  logic              fits;
  logic [DATA_W-1:0] a_mag, b_mag;

  assign a_mag  = a_i[DATA_W-1] ? DATA_W'(-a_i) : DATA_W'(a_i);
  assign b_mag  = b_i[DATA_W-1] ? DATA_W'(-b_i) : DATA_W'(b_i);
  assign rem_sh = {rem_q, numq_q[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      numq_q <= {a_mag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      den_q  <= b_mag;
      cnt_q  <= CW'(NW);
      neg_q  <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
      zero_q <= (b_i == '0);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        // one restoring step a cycle
        rem_q  <= fits ? DATA_W'(rem_sh - {1'b0, den_q}) : rem_sh[DATA_W-1:0];
        numq_q <= {numq_q[NW-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
      end else begin
        if (zero_q) quot_q <= '0;
        else if (!neg_q) begin
          if (numq_q > NW'(WORD_MAX)) quot_q <= WORD_MAX;
          else quot_q <= numq_q[DATA_W-1:0];
        end else begin
          if (numq_q > NW'({1'b1, {(DATA_W-1){1'b0}}})) quot_q <= WORD_MIN;
          else quot_q <= DATA_W'(-numq_q[DATA_W-1:0]);
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.zero = zero_q;
  assign res_o.quot = quot_q;

endmodule

/* hw/rtl/matrix_inverse_lu_core.sv */
// Matrix inverse by Doolittle LU factorization (no pivoting), signed fixed point with
// FRAC_BITS fraction bits. Load n*n elements row-major, one request per cycle while
// in_stall_o is low; n follows the size register (0 reads as 1, above MAX_N as MAX_N),
// and writing size drops a partly loaded matrix. After the last element the block
// stalls its input and runs elimination, forward substitution against the identity
// and back substitution, all on one shared multiplier (two-stage) and one shared
// radix-2 divider. The n*n results then leave one at a time: the next result is
// read only after the previous one is accepted. A zero pivot yields quotient zero
// and raises singular_o on every result of that matrix; last_o marks the final
// element. All sums, products and quotients saturate to 32 bits.
module matrix_inverse_lu_core #(
  parameter int MAX_N     = mil_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = mil_pkg::FRAC_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              size_we_i,
  input  logic [mil_pkg::SIZE_W-1:0]        size_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mil_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mil_pkg::DATA_W-1:0] value_res_o,
  output logic                              last_o,
  output logic                              singular_o
);
  import mil_pkg::*;

  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(MAX_N + 1);
  localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

  function automatic logic [AW-1:0] addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
    return AW'(int'(r) * MAX_N + int'(c));
  endfunction

  mil_state_e state_q, state_d;
  logic [SIZE_W-1:0] size_q;
  logic [RW-1:0] n;
  logic [RW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic signed [DATA_W-1:0] acc_q, acc_d, m_q, m_d, den_q, den_d;
  logic pz_q, pz_d;
  logic out_valid_q, out_valid_d, last_q, last_d, sing_q, sing_d;
  logic signed [DATA_W-1:0] out_val_q, out_val_d;

  // storage for U, L, forward result Z and the inverse X
  logic [DATA_W-1:0] u_mem [DEPTH];
  logic [DATA_W-1:0] l_mem [DEPTH];
  logic [DATA_W-1:0] z_mem [DEPTH];
  logic [DATA_W-1:0] x_mem [DEPTH];
  logic [AW-1:0] u_ra, u_wa, l_ra, l_wa, z_ra, z_wa, x_ra, x_wa;
  logic u_we, l_we, z_we, x_we;
  logic signed [DATA_W-1:0] u_wd, l_wd, z_wd, x_wd;
  logic signed [DATA_W-1:0] u_rd_q, l_rd_q, z_rd_q, x_rd_q;

  logic mul_start, div_start;
  logic signed [DATA_W-1:0] mul_a, mul_b, div_a, div_b;
  mul_res_t mul_res;
  div_res_t div_res;

  logic in_acc, out_acc;
  logic [RW:0] n_w, i_nx, j_nx, k_nx;

  always_comb begin
    if (size_q == '0) n = RW'(1);
    else if (int'(size_q) > MAX_N) n = RW'(MAX_N);
    else n = RW'(size_q);
  end

  assign n_w  = {1'b0, n};
  assign i_nx = {1'b0, i_q} + 1'b1;
  assign j_nx = {1'b0, j_q} + 1'b1;
  assign k_nx = {1'b0, k_q} + 1'b1;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  mil_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mul_res)
  );

  mil_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i) begin
    if (u_we) u_mem[u_wa] <= u_wd;
    u_rd_q <= u_mem[u_ra];
  end
  always_ff @(posedge clk_i) begin
    if (l_we) l_mem[l_wa] <= l_wd;
    l_rd_q <= l_mem[l_ra];
  end
  always_ff @(posedge clk_i) begin
    if (z_we) z_mem[z_wa] <= z_wd;
    z_rd_q <= z_mem[z_ra];
  end
  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[x_wa] <= x_wd;
    x_rd_q <= x_mem[x_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      size_q      <= SIZE_RST;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      pz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      pz_q        <= pz_d;
      out_valid_q <= out_valid_d;
      if (size_we_i) size_q <= size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    m_q       <= m_d;
    den_q     <= den_d;
    out_val_q <= out_val_d;
    last_q    <= last_d;
    sing_q    <= sing_d;
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    acc_d       = acc_q;
    m_d         = m_q;
    den_d       = den_q;
    pz_d        = pz_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    last_d      = last_q;
    sing_d      = sing_q;
    u_ra = '0; l_ra = '0; z_ra = '0; x_ra = '0;
    u_wa = '0; l_wa = '0; z_wa = '0; x_wa = '0;
    u_we = 1'b0; l_we = 1'b0; z_we = 1'b0; x_we = 1'b0;
    u_wd = value_i; l_wd = m_q; z_wd = '0; x_wd = '0;
    mul_start = 1'b0; mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_a = '0; div_b = '0;

    unique case (state_q)
      ST_LOAD: begin
        // i counts rows, j counts columns of the incoming matrix
        if (size_we_i) begin
          i_d = '0;
          j_d = '0;
        end else if (in_acc) begin
          u_we = 1'b1;
          u_wa = addr(i_q, j_q);
          u_wd = value_i;
          if (j_nx < n_w) begin
            j_d = RW'(j_nx);
          end else begin
            j_d = '0;
            if (i_nx < n_w) begin
              i_d = RW'(i_nx);
            end else begin
              pz_d = 1'b0;
              acc_d = '0;
              k_d = '0;
              if (n_w > 1) begin
                j_d = '0;
                i_d = RW'(1);
                state_d = ST_E_PIV;
              end else begin
                i_d = '0;
                state_d = ST_F_RD;
              end
            end
          end
        end
      end
      ST_E_PIV: begin
        u_ra = addr(j_q, j_q);
        state_d = ST_E_NUM;
      end
      ST_E_NUM: begin
        u_ra = addr(i_q, j_q);
        den_d = u_rd_q;
        state_d = ST_E_DIV;
      end
      ST_E_DIV: begin
        div_start = 1'b1;
        div_a = u_rd_q;
        div_b = den_q;
        state_d = ST_E_DWAIT;
      end
      ST_E_DWAIT: begin
        if (div_res.done) begin
          m_d  = div_res.quot;
          pz_d = pz_q | div_res.zero;
          l_we = 1'b1;
          l_wa = addr(i_q, j_q);
          l_wd = div_res.quot;
          k_d  = RW'(j_nx);
          state_d = ST_E_KRD;
        end
      end
      ST_E_KRD: begin
        u_ra = addr(j_q, k_q);
        state_d = ST_E_KMUL;
      end
      ST_E_KMUL: begin
        u_ra = addr(i_q, k_q);
        mul_start = 1'b1;
        mul_a = u_rd_q;
        mul_b = m_q;
        state_d = ST_E_KWAIT;
      end
      ST_E_KWAIT: begin
        // hold the read of U[i][k] until the product lands
        u_ra = addr(i_q, k_q);
        if (mul_res.done) begin
          u_we = 1'b1;
          u_wa = addr(i_q, k_q);
          u_wd = sat_sub(u_rd_q, mul_res.prod);
          if (k_nx < n_w) begin
            k_d = RW'(k_nx);
            state_d = ST_E_KRD;
          end else if (i_nx < n_w) begin
            i_d = RW'(i_nx);
            state_d = ST_E_PIV;
          end else if (j_nx + 1'b1 < n_w) begin
            j_d = RW'(j_nx);
            i_d = RW'(j_nx + 1'b1);
            state_d = ST_E_PIV;
          end else begin
            i_d = '0;
            j_d = '0;
            k_d = '0;
            acc_d = '0;
            state_d = ST_F_RD;
          end
        end
      end
      ST_F_RD: begin
        z_ra = addr(k_q, j_q);
        l_ra = addr(i_q, k_q);
        state_d = (k_q < i_q) ? ST_F_MUL : ST_F_WR;
      end
      ST_F_MUL: begin
        mul_start = 1'b1;
        mul_a = z_rd_q;
        mul_b = l_rd_q;
        state_d = ST_F_WAIT;
      end
      ST_F_WAIT: begin
        if (mul_res.done) begin
          acc_d = sat_add(acc_q, mul_res.prod);
          k_d = RW'(k_nx);
          state_d = ST_F_RD;
        end
      end
      ST_F_WR: begin
        z_we = 1'b1;
        z_wa = addr(i_q, j_q);
        z_wd = sat_sub((i_q == j_q) ? ONE : '0, acc_q);
        acc_d = '0;
        k_d = '0;
        state_d = ST_F_RD;
        if (j_nx < n_w) begin
          j_d = RW'(j_nx);
        end else begin
          j_d = '0;
          if (i_nx < n_w) begin
            i_d = RW'(i_nx);
          end else begin
            // back substitution walks column i upward from row n-1
            i_d = '0;
            j_d = RW'(n_w - 1'b1);
            k_d = n;
            state_d = ST_B_RD;
          end
        end
      end
      ST_B_RD: begin
        u_ra = addr(j_q, k_q);
        x_ra = addr(k_q, i_q);
        state_d = (k_q < n) ? ST_B_MUL : ST_B_RDZ;
      end
      ST_B_MUL: begin
        mul_start = 1'b1;
        mul_a = u_rd_q;
        mul_b = x_rd_q;
        state_d = ST_B_WAIT;
      end
      ST_B_WAIT: begin
        if (mul_res.done) begin
          acc_d = sat_add(acc_q, mul_res.prod);
          k_d = RW'(k_nx);
          state_d = ST_B_RD;
        end
      end
      ST_B_RDZ: begin
        z_ra = addr(j_q, i_q);
        u_ra = addr(j_q, j_q);
        state_d = ST_B_DIV;
      end
      ST_B_DIV: begin
        div_start = 1'b1;
        div_a = sat_sub(z_rd_q, acc_q);
        div_b = u_rd_q;
        state_d = ST_B_DWAIT;
      end
      ST_B_DWAIT: begin
        if (div_res.done) begin
          x_we = 1'b1;
          x_wa = addr(j_q, i_q);
          x_wd = div_res.quot;
          pz_d = pz_q | div_res.zero;
          acc_d = '0;
          if (j_q != '0) begin
            k_d = j_q;
            j_d = j_q - 1'b1;
            state_d = ST_B_RD;
          end else if (i_nx < n_w) begin
            i_d = RW'(i_nx);
            j_d = RW'(n_w - 1'b1);
            k_d = n;
            state_d = ST_B_RD;
          end else begin
            i_d = '0;
            j_d = '0;
            state_d = ST_O_RD;
          end
        end
      end
      ST_O_RD: begin
        x_ra = addr(i_q, j_q);
        state_d = ST_O_LD;
      end
      ST_O_LD: begin
        out_val_d   = x_rd_q;
        last_d      = (i_nx == n_w) && (j_nx == n_w);
        sing_d      = pz_q;
        out_valid_d = 1'b1;
        state_d     = ST_O_WAIT;
      end
      ST_O_WAIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (j_nx < n_w) begin
            j_d = RW'(j_nx);
            state_d = ST_O_RD;
          end else if (i_nx < n_w) begin
            j_d = '0;
            i_d = RW'(i_nx);
            state_d = ST_O_RD;
          end else begin
            i_d = '0;
            j_d = '0;
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = out_val_q;
  assign last_o      = last_q;
  assign singular_o  = sing_q;

endmodule

/* hw/rtl/mil_checker.sv */
module mil_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [mil_pkg::DATA_W-1:0] value_res_o,
  input logic                              last_o
);

  // no new matrix is taken while results are pending
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_res_o) && $stable(last_o))
    else $error("stalled result changed");

  // after the final element the block returns to loading
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o && !in_stall_o)
    else $error("not idle after last result");

endmodule

bind matrix_inverse_lu_core mil_checker u_mil_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_res_o (value_res_o),
  .last_o      (last_o)
);
